>>> rtl/scp_pkg.sv
package scp_pkg;

    localparam int BYTE_W    = 8;
    localparam int OP_W      = 3;
    localparam int VERDICT_W = 2;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 8;

    typedef enum logic [OP_W-1:0] {
        OP_LIKE  = 3'd0,
        OP_RLIKE = 3'd1,
        OP_SAME  = 3'd2,
        OP_RSAME = 3'd3,
        OP_LT    = 3'd4,
        OP_LTEQ  = 3'd5,
        OP_GT    = 3'd6,
        OP_GTEQ  = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        DIFF_NONE  = 2'd0,
        DIFF_BELOW = 2'd1,
        DIFF_ABOVE = 2'd2,
        DIFF_RSVD  = 2'd3
    } diff_t;

    localparam logic [VERDICT_W-1:0] VERDICT_TRUE_1  = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_TRUE_2  = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_FALSE_1 = 2'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_FALSE_2 = 2'd3;

    typedef struct packed {
        diff_t first_difference;
        logic  a_ended;
        logic  b_ended;
    } scp_state_t;

    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            return c + 8'h20;
        end
        return c;
    endfunction

endpackage

>>> rtl/scp_step.sv
module scp_step (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  scp_pkg::op_t               op,
    input  logic [scp_pkg::BYTE_W-1:0] byte_a,
    input  logic                       a_present,
    input  logic [scp_pkg::BYTE_W-1:0] byte_b,
    input  logic                       b_present,
    input  logic                       last,
    output scp_pkg::scp_state_t        state_next
);
    import scp_pkg::*;

    scp_state_t         state_reg;
    logic               fold_en;
    logic [BYTE_W-1:0]  ca;
    logic [BYTE_W-1:0]  cb;

    assign fold_en = (op == OP_LIKE) || (op == OP_RLIKE) || (op == OP_SAME)
                     || (op == OP_RSAME);
    assign ca = fold_en ? fold_byte(byte_a) : byte_a;
    assign cb = fold_en ? fold_byte(byte_b) : byte_b;

    always_comb
    begin
        state_next = state_reg;
        if (!state_reg.a_ended && !state_reg.b_ended)
        begin
            if (a_present && b_present)
            begin
                if (state_reg.first_difference == DIFF_NONE)
                begin
                    if (ca < cb)
                    begin
                        state_next.first_difference = DIFF_BELOW;
                    end
                    else if (ca > cb)
                    begin
                        state_next.first_difference = DIFF_ABOVE;
                    end
                end
            end
            else
            begin
                state_next.a_ended = !a_present;
                state_next.b_ended = !b_present;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= last ? scp_state_t'('0) : state_next;
        end
    end

endmodule

>>> rtl/scp_decide.sv
module scp_decide (
    input  scp_pkg::op_t                  op,
    input  scp_pkg::scp_state_t           st,
    output logic [scp_pkg::VERDICT_W-1:0] verdict
);
    import scp_pkg::*;

    logic a_short;
    logic b_short;
    logic diff_seen;
    logic below;
    logic above;
    logic equal;

    assign a_short   = st.a_ended && !st.b_ended;
    assign b_short   = st.b_ended && !st.a_ended;
    assign diff_seen = st.first_difference != DIFF_NONE;
    assign below     = (st.first_difference == DIFF_BELOW)
                       || (!diff_seen && a_short);
    assign above     = (st.first_difference == DIFF_ABOVE)
                       || (!diff_seen && b_short);
    assign equal     = !below && !above;

    always_comb
    begin
        unique case (op)
            OP_LIKE:  verdict = a_short ? VERDICT_FALSE_1
                              : (diff_seen ? VERDICT_FALSE_2 : VERDICT_TRUE_1);
            OP_RLIKE: verdict = b_short ? VERDICT_TRUE_1
                              : (diff_seen ? VERDICT_TRUE_2 : VERDICT_FALSE_1);
            OP_SAME:  verdict = equal ? VERDICT_TRUE_1
                              : (below ? VERDICT_FALSE_1 : VERDICT_FALSE_2);
            OP_RSAME: verdict = equal ? VERDICT_FALSE_1
                              : (below ? VERDICT_TRUE_1 : VERDICT_TRUE_2);
            OP_LT:    verdict = below ? VERDICT_TRUE_1 : VERDICT_FALSE_1;
            OP_LTEQ:  verdict = (below || equal) ? VERDICT_TRUE_1 : VERDICT_FALSE_1;
            OP_GT:    verdict = above ? VERDICT_TRUE_1 : VERDICT_FALSE_1;
            OP_GTEQ:  verdict = (above || equal) ? VERDICT_TRUE_1 : VERDICT_FALSE_1;
            default:  verdict = VERDICT_FALSE_1;
        endcase
    end

endmodule

>>> rtl/string_compare_predicates.sv
// String compare predicates.
// Slave stream: one beat per string position. s_tdata carries byte_a, a_present,
// byte_b, b_present; s_tlast marks the final position of a comparison.
// Master stream: one beat per comparison, carrying the 2-bit verdict for the
// operator in force when the final position is processed.
// Config channel: cfg_data sets the 3-bit operator; write only while idle.
// Throughput: one beat per cycle unless a last beat waits on the result
// register, set by a single compare and state update between the input
// register and the result register. A last beat moves from the input register
// to the result register, which drives m_tvalid, once that register is free.
// Reset clears the operator to LIKE, the compare state and both valid flags.
// A stall on m_tready holds the verdict; non-last beats keep flowing until a
// second last beat waits in the input register, then s_tready drops.
module string_compare_predicates (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] byte_a, [8] a_present, [16:9] byte_b, [17] b_present, [23:18] zero
    input  logic [scp_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [1:0] verdict, [7:2] zero
    output logic [scp_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [scp_pkg::OP_W-1:0]       cfg_data
);
    import scp_pkg::*;

    op_t                   op_reg;
    logic                  in_valid_reg;
    logic [BYTE_W-1:0]     byte_a_reg;
    logic                  a_present_reg;
    logic [BYTE_W-1:0]     byte_b_reg;
    logic                  b_present_reg;
    logic                  last_reg;
    logic                  out_valid_reg;
    logic [VERDICT_W-1:0]  verdict_reg;

    logic                  out_free;
    logic                  advance;
    logic                  s_accept;
    scp_state_t            state_next;
    logic [VERDICT_W-1:0]  verdict_next;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && (!last_reg || out_free);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(M_DATA_W-VERDICT_W){1'b0}}, verdict_reg};

    scp_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .op         (op_reg),
        .byte_a     (byte_a_reg),
        .a_present  (a_present_reg),
        .byte_b     (byte_b_reg),
        .b_present  (b_present_reg),
        .last       (last_reg),
        .state_next (state_next)
    );

    scp_decide u_decide (
        .op      (op_reg),
        .st      (state_next),
        .verdict (verdict_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= OP_LIKE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            op_reg <= op_t'(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance && last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold payload until the next accepted beat.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            byte_a_reg    <= s_tdata[7:0];
            a_present_reg <= s_tdata[8];
            byte_b_reg    <= s_tdata[16:9];
            b_present_reg <= s_tdata[17];
            last_reg      <= s_tlast;
        end
        if (advance && last_reg)
        begin
            verdict_reg <= verdict_next;
        end
    end

endmodule

>>> rtl/scp_checker.sv
module scp_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         s_tlast,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [scp_pkg::M_DATA_W-1:0] m_tdata
);
    import scp_pkg::*;

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output beat changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[M_DATA_W-1:VERDICT_W] == '0)
        else $error("output padding not zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
        else $error("output beat without a last input beat");

endmodule

bind string_compare_predicates scp_checker u_scp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
